@@ rtl/core/dtrc_pkg.sv @@
// ---------------------------------------------------------------------------
// Depth colouriser shared definitions
// Types, register indexes, colour mode codes and the constant rainbow palette
// used by the stages of the depth-to-RGBA colouriser.
// ---------------------------------------------------------------------------
package dtrc_pkg;

  // Width of the depth sample that takes part in the colouring.
  localparam int unsigned DEPTH_W = 16;

  // Reciprocal of ten for a 16-bit dividend: x / 10 == (x * 52429) >> 19.
  localparam logic [15:0] RECIP10     = 16'hCCCD;
  localparam int unsigned RECIP10_SHR = 19;

  // Number of division cells, one per quotient bit of the palette index.
  localparam int unsigned NUM_CELLS = 8;

  // Register indexes of the configuration port.
  localparam logic REG_COLOR_MODE  = 1'b0;
  localparam logic REG_DEPTH_RANGE = 1'b1;

  // Colour modes.
  typedef enum logic [1:0] {
    MODE_SHADED  = 2'd0,
    MODE_PSYCH   = 2'd1,
    MODE_RAINBOW = 2'd2,
    MODE_CYCLIC  = 2'd3
  } color_mode_e;

  localparam color_mode_e RESET_COLOR_MODE  = MODE_RAINBOW;
  localparam logic [15:0] RESET_DEPTH_RANGE = 16'd10000;

  // Word handed from cell to cell along the chain.
  typedef struct packed {
    logic       zero;   // depth was zero
    logic       ovf;    // rainbow index saturates at 255
    logic [7:0] rem;    // partial remainder of the scaling division
    logic [7:0] num;    // dividend bits still to be shifted in
    logic [7:0] quo;    // quotient bits produced so far
    logic [7:0] cyc;    // low depth byte, cyclic palette index
    logic [3:0] units;  // depth mod 10
    logic [3:0] tens;   // (depth / 10) mod 10
  } cell_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef rgb_t [255:0] pal_t;

  // Value in hundredths truncated toward zero, negatives clamped to zero.
  function automatic logic [7:0] hundredths_to_byte(int v);
    int q;
    q = v / 100;
    if (v < 0) begin
      return 8'd0;
    end else if (q > 255) begin
      return 8'd255;
    end
    return 8'(q);
  endfunction

  // Five linear pieces of the rainbow, evaluated once at elaboration.
  function automatic pal_t build_palette();
    pal_t p;
    for (int i = 0; i < 256; i++) begin
      p[i] = '0;
      if (i == 0 || i == 255) begin
        p[i] = '0;
      end else if (i <= 29) begin
        p[i].r = hundredths_to_byte(12936 - 436 * i);
        p[i].b = 8'd255;
      end else if (i <= 86) begin
        p[i].g = hundredths_to_byte(-13354 + 452 * i);
        p[i].b = 8'd255;
      end else if (i <= 141) begin
        p[i].g = 8'd255;
        p[i].b = hundredths_to_byte(66583 - 472 * i);
      end else if (i <= 199) begin
        p[i].r = hundredths_to_byte(-63526 + 447 * i);
        p[i].g = 8'd255;
      end else begin
        p[i].r = 8'd255;
        p[i].g = hundredths_to_byte(116681 - 457 * i);
      end
    end
    return p;
  endfunction

  localparam pal_t PALETTE = build_palette();

endpackage

@@ rtl/core/dtrc_front.sv @@
// ---------------------------------------------------------------------------
// Depth colouriser front end
// Three registered stages that split the depth into its decimal digits and
// prepare the operands of the scaling division for the cell chain.
// ---------------------------------------------------------------------------
module dtrc_front import dtrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         divisor_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [DEPTH_W-1:0] depth_i,
  output logic               valid_o,
  input  logic               ready_i,
  output cell_t              data_o
);

  logic               vld_a_q, vld_b_q, vld_c_q;
  logic               rdy_a, rdy_b, rdy_c;

  logic [DEPTH_W-1:0] depth_a_q, depth_b_q;
  logic [12:0]        q10_a_q, q10_b_q;
  logic               zero_a_q, zero_b_q;
  logic               ovf_a_q, ovf_b_q;
  logic [3:0]         units_b_q;
  logic [9:0]         q100_b_q;
  cell_t              data_c_q;

  logic [31:0]        prod_a;
  logic [28:0]        prod_b;
  logic [15:0]        tens10_a;
  logic [15:0]        units_d;
  logic [12:0]        q100x10;
  logic [12:0]        tens_d;

  // Each stage loads when it is empty or its successor moves on.
  assign rdy_c   = !vld_c_q || ready_i;
  assign rdy_b   = !vld_b_q || rdy_c;
  assign rdy_a   = !vld_a_q || rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = vld_c_q;
  assign data_o  = data_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= valid_i;
      if (rdy_b) vld_b_q <= vld_a_q;
      if (rdy_c) vld_c_q <= vld_b_q;
    end
  end

  // Stage A: depth / 10 by reciprocal, zero test and saturation test.
  assign prod_a = 32'(depth_i) * 32'(RECIP10);

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) begin
      depth_a_q <= depth_i;
      q10_a_q   <= 13'(prod_a >> RECIP10_SHR);
      zero_a_q  <= (depth_i == '0);
      ovf_a_q   <= (divisor_i == 8'd0) || (depth_i[15:8] >= divisor_i);
    end
  end

  // Stage B: units digit, and the quotient by one hundred.
  assign tens10_a = (16'(q10_a_q) << 3) + (16'(q10_a_q) << 1);
  assign units_d  = depth_a_q - tens10_a;
  assign prod_b   = 29'(q10_a_q) * 29'(RECIP10);

  always_ff @(posedge clk_i) begin
    if (rdy_b && vld_a_q) begin
      depth_b_q <= depth_a_q;
      q10_b_q   <= q10_a_q;
      zero_b_q  <= zero_a_q;
      ovf_b_q   <= ovf_a_q;
      units_b_q <= units_d[3:0];
      q100_b_q  <= 10'(prod_b >> RECIP10_SHR);
    end
  end

  // Stage C: tens digit, and the word that enters the first division cell.
  assign q100x10 = (13'(q100_b_q) << 3) + (13'(q100_b_q) << 1);
  assign tens_d  = q10_b_q - q100x10;

  always_ff @(posedge clk_i) begin
    if (rdy_c && vld_b_q) begin
      data_c_q.zero  <= zero_b_q;
      data_c_q.ovf   <= ovf_b_q;
      data_c_q.rem   <= depth_b_q[15:8];
      data_c_q.num   <= depth_b_q[7:0];
      data_c_q.quo   <= 8'd0;
      data_c_q.cyc   <= depth_b_q[7:0];
      data_c_q.units <= units_b_q;
      data_c_q.tens  <= tens_d[3:0];
    end
  end

endmodule

@@ rtl/core/dtrc_div_cell.sv @@
// ---------------------------------------------------------------------------
// Depth colouriser division cell
// One restoring division step: shifts in one dividend bit, compares with the
// divisor and hands the new remainder and quotient bit to the next cell.
// ---------------------------------------------------------------------------
module dtrc_div_cell import dtrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] divisor_i,
  input  logic       valid_i,
  output logic       ready_o,
  input  cell_t      data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output cell_t      data_o
);

  logic       valid_q;
  cell_t      data_q;
  cell_t      data_d;
  logic [8:0] trial;
  logic [8:0] diff;
  logic       fits;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {data_i.rem, data_i.num[7]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    data_d     = data_i;
    data_d.rem = fits ? diff[7:0] : trial[7:0];
    data_d.num = {data_i.num[6:0], 1'b0};
    data_d.quo = {data_i.quo[6:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

@@ rtl/core/dtrc_back.sv @@
// ---------------------------------------------------------------------------
// Depth colouriser output stage
// Picks the palette or the ten-colour set by mode, forms alpha and holds the
// finished RGBA word in the output register.
// ---------------------------------------------------------------------------
module dtrc_back import dtrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  color_mode_e color_mode_i,
  input  logic        valid_i,
  output logic        ready_o,
  input  cell_t       data_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] rgba_o
);

  logic        valid_q;
  logic [31:0] rgba_q;
  logic [7:0]  pal_idx;
  rgb_t        pal_rgb;
  rgb_t        psy_rgb;
  rgb_t        rgb;
  logic [9:0]  shade_sum;
  logic [7:0]  alpha;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign rgba_o  = rgba_q;

  // Palette lookup: cyclic by the low depth byte, else the scaled index.
  assign pal_idx = (color_mode_i == MODE_CYCLIC) ? data_i.cyc :
                   (data_i.ovf ? 8'hFF : data_i.quo);
  assign pal_rgb = PALETTE[pal_idx];

  // Ten fixed colours chosen by the tens digit.
  always_comb begin
    case (data_i.tens)
      4'd0:    psy_rgb = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      4'd1:    psy_rgb = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      4'd2:    psy_rgb = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      4'd3:    psy_rgb = '{r: 8'd255, g: 8'd255, b: 8'd0};
      4'd4:    psy_rgb = '{r: 8'd0,   g: 8'd255, b: 8'd255};
      4'd5:    psy_rgb = '{r: 8'd255, g: 8'd0,   b: 8'd255};
      4'd6:    psy_rgb = '{r: 8'd255, g: 8'd255, b: 8'd255};
      4'd7:    psy_rgb = '{r: 8'd127, g: 8'd0,   b: 8'd255};
      4'd8:    psy_rgb = '{r: 8'd255, g: 8'd0,   b: 8'd127};
      default: psy_rgb = '{r: 8'd127, g: 8'd255, b: 8'd0};
    endcase
  end

  // Colour and alpha; shaded alpha follows the units digit, no reading is clear.
  assign shade_sum = 10'd510 + 10'(data_i.units) * 10'd51;

  always_comb begin
    rgb   = pal_rgb;
    alpha = 8'd255;
    if (color_mode_i == MODE_SHADED || color_mode_i == MODE_PSYCH) begin
      rgb = psy_rgb;
    end
    if (color_mode_i == MODE_SHADED) begin
      alpha = shade_sum[9:2];
    end
    if (data_i.zero) begin
      alpha = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rgba_q <= {alpha, rgb.b, rgb.g, rgb.r};
    end
  end

endmodule

@@ rtl/core/depth_to_rgba_colorizer_top.sv @@
// ---------------------------------------------------------------------------
// Depth to RGBA false-colour block
// Turns each 16-bit depth pixel into a red, green, blue and alpha byte in one
// of four colour modes, as a pipeline with one word per clock unless stalled.
// ---------------------------------------------------------------------------
// The block takes one depth word per clock unless the output stalls; three
// front stages split off the decimal digits, a chain of eight division cells
// forms the rainbow palette index one quotient bit per cell, and one output
// stage does the colour lookup and holds the result. Each stage keeps its
// word while the next stage is full, so empty slots are closed up and new
// words are taken while a finished word waits at the output. Configuration
// must be written only while the pipeline is empty, which is not enforced.
module depth_to_rgba_colorizer_top import dtrc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  // Depth words in
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DEPTH_W-1:0] s_axis_tdata,   // [15:0] depth
  // Colour words out
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata    // [7:0] red, [15:8] green,
                                             // [23:16] blue, [31:24] alpha
);

  color_mode_e color_mode_q;
  logic [15:0] depth_range_q;
  logic [7:0]  divisor;

  cell_t chain_data  [NUM_CELLS+1];
  logic  chain_valid [NUM_CELLS+1];
  logic  chain_ready [NUM_CELLS+1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q  <= RESET_COLOR_MODE;
      depth_range_q <= RESET_DEPTH_RANGE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COLOR_MODE:  color_mode_q  <= color_mode_e'(cfg_data_i[1:0]);
        REG_DEPTH_RANGE: depth_range_q <= cfg_data_i;
        default:         depth_range_q <= depth_range_q;
      endcase
    end
  end

  // Rainbow scale divisor is the top byte of the largest depth.
  assign divisor = depth_range_q[15:8];

  dtrc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .divisor_i (divisor),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .depth_i   (s_axis_tdata),
    .valid_o   (chain_valid[0]),
    .ready_i   (chain_ready[0]),
    .data_o    (chain_data[0])
  );

  // Chain of division cells, one quotient bit each.
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    dtrc_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (divisor),
      .valid_i   (chain_valid[k]),
      .ready_o   (chain_ready[k]),
      .data_i    (chain_data[k]),
      .valid_o   (chain_valid[k+1]),
      .ready_i   (chain_ready[k+1]),
      .data_o    (chain_data[k+1])
    );
  end

  dtrc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .color_mode_i (color_mode_q),
    .valid_i      (chain_valid[NUM_CELLS]),
    .ready_o      (chain_ready[NUM_CELLS]),
    .data_i       (chain_data[NUM_CELLS]),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .rgba_o       (m_axis_tdata)
  );

endmodule
